// ----- src/ppgema_pkg.sv -----
`timescale 1ns / 1ps

package ppgema_pkg;

   localparam int SAMPLE_W = 12;
   localparam int COEFF_W  = 17;
   localparam int LEVEL_W  = 12;
   localparam int PULSE_W  = 13;
   localparam int COUNT_W  = 14;
   localparam int ACC_W    = 28;  // Q12.16 unsigned
   localparam int PACC_W   = 29;  // Q13.16 signed
   localparam int DIFF_W   = 30;
   localparam int PROD_W   = 48;
   localparam int RND_W    = 31;
   localparam int SUM_W    = 32;
   localparam int STEP_W   = 3;
   localparam int ADDR_W   = 3;
   localparam int FRAC_W   = 16;

   localparam logic [COEFF_W-1:0] ONE_Q16 = 17'd65536;
   localparam logic [PROD_W-1:0]  HALF_Q16 = 48'd32768;

   localparam logic [COEFF_W-1:0] SMOOTH_COEFF_RST   = 17'd18725;
   localparam logic [COEFF_W-1:0] BASELINE_COEFF_RST = 17'd542;
   localparam logic [COEFF_W-1:0] PULSE_COEFF_RST    = 17'd21845;
   localparam logic [LEVEL_W-1:0] WEAR_LEVEL_RST     = 12'd0;
   localparam logic [COUNT_W-1:0] DEBOUNCE_RST       = 14'd25;

   localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;

   typedef enum logic [ADDR_W-1:0] {
      REG_SMOOTH_COEFF   = 3'd0,
      REG_BASELINE_COEFF = 3'd1,
      REG_PULSE_COEFF    = 3'd2,
      REG_WEAR_LEVEL     = 3'd3,
      REG_DEBOUNCE       = 3'd4
   } reg_addr_type;

   // which ema stage the datapath works on
   typedef enum logic [1:0] {
      SEL_SMOOTH   = 2'd0,
      SEL_BASELINE = 2'd1,
      SEL_PULSE    = 2'd2
   } sel_type;

   typedef struct packed {
      logic    hold_req;  // stay until a request is taken
      logic    hold_rsp;  // stay while the output register is full
      logic    mul_en;    // register coeff * (target - acc)
      logic    acc_en;    // acc += rounded product
      logic    out_en;    // round, debounce, load output register
      logic    last;      // jump back to idle
      sel_type sel;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '{hold_req: 1'b0, hold_rsp: 1'b0, mul_en: 1'b0, acc_en: 1'b0,
             out_en: 1'b0, last: 1'b0, sel: SEL_SMOOTH};
      case (step)
         3'd0: uc.hold_req = 1'b1;
         3'd1: begin uc.mul_en = 1'b1; uc.sel = SEL_SMOOTH;   end
         3'd2: begin uc.acc_en = 1'b1; uc.sel = SEL_SMOOTH;   end
         3'd3: begin uc.mul_en = 1'b1; uc.sel = SEL_BASELINE; end
         3'd4: begin uc.acc_en = 1'b1; uc.sel = SEL_BASELINE; end
         3'd5: begin uc.mul_en = 1'b1; uc.sel = SEL_PULSE;    end
         3'd6: begin uc.acc_en = 1'b1; uc.sel = SEL_PULSE;    end
         3'd7: begin
            uc.out_en   = 1'b1;
            uc.hold_rsp = 1'b1;
            uc.last     = 1'b1;
         end
         default: uc.hold_req = 1'b1;
      endcase
      return uc;
   endfunction

endpackage

// ----- src/ppg_ema_chain_with_wear_debounce.sv -----
`timescale 1ns / 1ps

// an 8-step microprogram runs all three ema updates through one shared 30x18
// multiplier; a new request is taken only once the previous one has left the
// last step, and the last step also waits while the output register holds a
// result that rsp_tready has not taken
// reset: synchronous, active high; clears filter state, counters and wear flag,
// loads default coefficients, wear level and debounce count
module ppg_ema_chain_with_wear_debounce (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] level, [24:12] pulse
   output logic        rsp_tuser,   // [0] worn
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [16:0] csr_wdata
);

   logic [ppgema_pkg::COEFF_W-1:0] smooth_coeff_ff, baseline_coeff_ff, pulse_coeff_ff;
   logic [ppgema_pkg::LEVEL_W-1:0] wear_level_ff;
   logic [ppgema_pkg::COUNT_W-1:0] debounce_ff;

   logic [ppgema_pkg::STEP_W-1:0]   step_ff, step_in;
   ppgema_pkg::ucode_type           uc;
   logic                            seeded_ff;
   logic [ppgema_pkg::SAMPLE_W-1:0] x_ff;
   logic [ppgema_pkg::ACC_W-1:0]    smooth_ff, base_ff;
   logic signed [ppgema_pkg::PACC_W-1:0] pulse_ff;
   logic signed [ppgema_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [ppgema_pkg::COUNT_W-1:0]  above_ff, below_ff, above_in, below_in;
   logic                            worn_ff, worn_in;
   logic                            rsp_valid_ff;
   logic [ppgema_pkg::LEVEL_W-1:0]  level_ff;
   logic [ppgema_pkg::PULSE_W-1:0]  pulse_out_ff, pulse_sat;

   logic                            req_fire, out_busy, out_fire;
   logic signed [ppgema_pkg::DIFF_W-1:0] acc_op, tgt_op, diff;
   logic [ppgema_pkg::COEFF_W-1:0]  coeff_raw, coeff;
   logic [ppgema_pkg::PROD_W-1:0]   prod_mag;
   logic [ppgema_pkg::RND_W-1:0]    rnd_mag;
   logic signed [ppgema_pkg::SUM_W-1:0] rnd_s, acc_sum;
   logic [ppgema_pkg::LEVEL_W:0]    lvl_r;
   logic [ppgema_pkg::PACC_W-1:0]   pmag;
   logic [ppgema_pkg::COUNT_W-1:0]  prnd;
   logic signed [ppgema_pkg::COUNT_W-1:0] ps;
   logic                            high;

   assign uc         = ppgema_pkg::ucode_rom(step_ff);
   assign req_tready = uc.hold_req;
   assign req_fire   = req_tvalid && uc.hold_req;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign out_fire   = uc.out_en && !out_busy;

   // sequencer
   always_comb begin
      if (uc.hold_req && !req_fire) begin
         step_in = step_ff;
      end else if (uc.hold_rsp && out_busy) begin
         step_in = step_ff;
      end else if (uc.last) begin
         step_in = ppgema_pkg::STEP_IDLE;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // operand selection
   always_comb begin
      case (uc.sel)
         ppgema_pkg::SEL_SMOOTH: begin
            acc_op    = $signed({2'b00, smooth_ff});
            tgt_op    = $signed({2'b00, x_ff, 16'h0000});
            coeff_raw = smooth_coeff_ff;
         end
         ppgema_pkg::SEL_BASELINE: begin
            acc_op    = $signed({2'b00, base_ff});
            tgt_op    = $signed({2'b00, smooth_ff});
            coeff_raw = baseline_coeff_ff;
         end
         ppgema_pkg::SEL_PULSE: begin
            acc_op    = {pulse_ff[ppgema_pkg::PACC_W-1], pulse_ff};
            tgt_op    = $signed({2'b00, smooth_ff}) - $signed({2'b00, base_ff});
            coeff_raw = pulse_coeff_ff;
         end
         default: begin
            acc_op    = '0;
            tgt_op    = '0;
            coeff_raw = '0;
         end
      endcase
      coeff   = (coeff_raw > ppgema_pkg::ONE_Q16) ? ppgema_pkg::ONE_Q16 : coeff_raw;
      diff    = tgt_op - acc_op;
      prod_in = diff * $signed({1'b0, coeff});
   end

   // round half away from zero, then accumulate
   always_comb begin
      prod_mag = prod_ff[ppgema_pkg::PROD_W-1] ? ppgema_pkg::PROD_W'(-prod_ff)
                                                : ppgema_pkg::PROD_W'(prod_ff);
      rnd_mag  = ppgema_pkg::RND_W'((prod_mag + ppgema_pkg::HALF_Q16) >> ppgema_pkg::FRAC_W);
      rnd_s    = prod_ff[ppgema_pkg::PROD_W-1] ? -$signed({1'b0, rnd_mag})
                                                :  $signed({1'b0, rnd_mag});
      acc_sum  = $signed({{2{acc_op[ppgema_pkg::DIFF_W-1]}}, acc_op}) + rnd_s;
   end

   // output rounding, saturation and wear debounce
   always_comb begin
      lvl_r = 13'(({1'b0, smooth_ff} + 29'd32768) >> 16);
      pmag  = pulse_ff[ppgema_pkg::PACC_W-1] ? ppgema_pkg::PACC_W'(-pulse_ff)
                                             : ppgema_pkg::PACC_W'(pulse_ff);
      prnd  = ppgema_pkg::COUNT_W'(({1'b0, pmag} + 30'd32768) >> 16);
      ps    = pulse_ff[ppgema_pkg::PACC_W-1] ? -$signed(prnd) : $signed(prnd);
      if (ps > 14'sd4095) begin
         pulse_sat = 13'h0FFF;
      end else if (ps < -14'sd4096) begin
         pulse_sat = 13'h1000;
      end else begin
         pulse_sat = ps[ppgema_pkg::PULSE_W-1:0];
      end

      high     = lvl_r > {1'b0, wear_level_ff};
      above_in = above_ff;
      below_in = below_ff;
      worn_in  = worn_ff;
      if (high) begin
         below_in = '0;
         if (above_ff < debounce_ff) begin
            above_in = above_ff + 1'b1;
         end
         if (above_in >= debounce_ff) begin
            worn_in = 1'b1;
         end
      end else begin
         above_in = '0;
         if (below_ff < debounce_ff) begin
            below_in = below_ff + 1'b1;
         end
         if (below_in >= debounce_ff) begin
            worn_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_coeff_ff   <= ppgema_pkg::SMOOTH_COEFF_RST;
         baseline_coeff_ff <= ppgema_pkg::BASELINE_COEFF_RST;
         pulse_coeff_ff    <= ppgema_pkg::PULSE_COEFF_RST;
         wear_level_ff     <= ppgema_pkg::WEAR_LEVEL_RST;
         debounce_ff       <= ppgema_pkg::DEBOUNCE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            ppgema_pkg::REG_SMOOTH_COEFF:   smooth_coeff_ff   <= csr_wdata;
            ppgema_pkg::REG_BASELINE_COEFF: baseline_coeff_ff <= csr_wdata;
            ppgema_pkg::REG_PULSE_COEFF:    pulse_coeff_ff    <= csr_wdata;
            ppgema_pkg::REG_WEAR_LEVEL:
               wear_level_ff <= csr_wdata[ppgema_pkg::LEVEL_W-1:0];
            ppgema_pkg::REG_DEBOUNCE:
               debounce_ff <= csr_wdata[ppgema_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ppgema_pkg::STEP_IDLE;
         seeded_ff    <= 1'b0;
         smooth_ff    <= '0;
         base_ff      <= '0;
         pulse_ff     <= '0;
         above_ff     <= '0;
         below_ff     <= '0;
         worn_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (req_fire && !seeded_ff) begin
            // first sample seeds both averages
            seeded_ff <= 1'b1;
            smooth_ff <= {req_tdata[ppgema_pkg::SAMPLE_W-1:0], 16'h0000};
            base_ff   <= {req_tdata[ppgema_pkg::SAMPLE_W-1:0], 16'h0000};
            pulse_ff  <= '0;
         end
         if (uc.acc_en) begin
            case (uc.sel)
               ppgema_pkg::SEL_SMOOTH:   smooth_ff <= acc_sum[ppgema_pkg::ACC_W-1:0];
               ppgema_pkg::SEL_BASELINE: base_ff   <= acc_sum[ppgema_pkg::ACC_W-1:0];
               ppgema_pkg::SEL_PULSE:    pulse_ff  <= acc_sum[ppgema_pkg::PACC_W-1:0];
               default: ;
            endcase
         end
         if (out_fire) begin
            above_ff     <= above_in;
            below_ff     <= below_in;
            worn_ff      <= worn_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff <= req_tdata[ppgema_pkg::SAMPLE_W-1:0];
      end
      if (uc.mul_en) begin
         prod_ff <= prod_in;
      end
      if (out_fire) begin
         level_ff     <= lvl_r[ppgema_pkg::LEVEL_W] ? 12'hFFF
                                                    : lvl_r[ppgema_pkg::LEVEL_W-1:0];
         pulse_out_ff <= pulse_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, pulse_out_ff, level_ff};
   assign rsp_tuser  = worn_ff;

`ifndef SYNTHESIS
   a_req_starts_program: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (step_ff == 3'd1))
      else $error("accepted request did not start the microprogram");

   a_out_loads_valid: assert property (@(posedge clock) disable iff (reset)
      out_fire |=> rsp_valid_ff)
      else $error("finished item did not reach the output register");

   a_one_run_counter: assert property (@(posedge clock) disable iff (reset)
      !(above_ff != '0 && below_ff != '0))
      else $error("above and below run counters both nonzero");

   a_worn_debounced: assert property (@(posedge clock) disable iff (reset)
      (worn_ff != $past(worn_ff)) |->
         (worn_ff ? (above_ff >= debounce_ff) : (below_ff >= debounce_ff)))
      else $error("wear flag changed without a full debounce run");

   a_seed_once: assert property (@(posedge clock) disable iff (reset)
      seeded_ff |=> seeded_ff)
      else $error("seeded flag dropped");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS   = 10;
   localparam int SAMPLE_MAX    = 4095;
   localparam int PULSE_MAX     = 4095;
   localparam int PULSE_MIN     = -4096;
   localparam int DEBOUNCE_MAX  = 16383;
   localparam int COEFF_MAX     = 131071;
   localparam int COEFF_ONE     = int'(ppgema_pkg::ONE_Q16);
   localparam logic [ppgema_pkg::ADDR_W-1:0] REG_FIRST_UNUSED = 3'd5;

   typedef struct packed {
      logic [ppgema_pkg::LEVEL_W-1:0] level;
      logic [ppgema_pkg::PULSE_W-1:0] pulse;
      logic                           worn;
   } reading_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [16:0] csr_wdata  = '0;

   // filter configuration as the block should hold it
   int k_smooth   = int'(ppgema_pkg::SMOOTH_COEFF_RST);
   int k_base     = int'(ppgema_pkg::BASELINE_COEFF_RST);
   int k_pulse    = int'(ppgema_pkg::PULSE_COEFF_RST);
   int wear_thr   = int'(ppgema_pkg::WEAR_LEVEL_RST);
   int settle_len = int'(ppgema_pkg::DEBOUNCE_RST);

   // filter state, q.16
   bit     primed     = 1'b0;
   longint smooth_q   = 0;
   longint base_q     = 0;
   longint pulse_q    = 0;
   int     above_run  = 0;
   int     below_run  = 0;
   bit     worn_state = 1'b0;

   reading_type pending_readings[$];
   int mismatches  = 0;
   int cycle_count = 0;
   int gap_pct     = 0;
   int stall_pct   = 0;

   ppg_ema_chain_with_wear_debounce u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("tb failed");
      $finish;
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   // divide by 2^16, ties away from zero
   function automatic longint round_away_q16(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + 32768) >>> ppgema_pkg::FRAC_W;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint ema_update(longint acc, longint target, int k);
      longint kk;
      kk = (k > COEFF_ONE) ? longint'(COEFF_ONE) : longint'(k);
      return acc + round_away_q16(kk * (target - acc));
   endfunction

   function automatic int clamp_sample(int v);
      return (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
   endfunction

   task automatic advance_filter_chain(input logic [ppgema_pkg::SAMPLE_W-1:0] s);
      longint x, lvl, pul;
      reading_type r;
      x = longint'(s) <<< ppgema_pkg::FRAC_W;
      if (!primed) begin
         smooth_q = x;
         base_q   = x;
         pulse_q  = 0;
         primed   = 1'b1;
      end
      smooth_q = ema_update(smooth_q, x, k_smooth);
      base_q   = ema_update(base_q, smooth_q, k_base);
      pulse_q  = ema_update(pulse_q, smooth_q - base_q, k_pulse);
      lvl = round_away_q16(smooth_q);
      pul = round_away_q16(pulse_q);
      if (lvl > longint'(wear_thr)) begin
         below_run = 0;
         if (above_run < settle_len) above_run++;
         if (above_run >= settle_len) worn_state = 1'b1;
      end else begin
         above_run = 0;
         if (below_run < settle_len) below_run++;
         if (below_run >= settle_len) worn_state = 1'b0;
      end
      if (lvl > SAMPLE_MAX) lvl = SAMPLE_MAX;
      if (lvl < 0) lvl = 0;
      if (pul > PULSE_MAX) pul = PULSE_MAX;
      if (pul < PULSE_MIN) pul = PULSE_MIN;
      r.level = lvl[ppgema_pkg::LEVEL_W-1:0];
      r.pulse = pul[ppgema_pkg::PULSE_W-1:0];
      r.worn  = worn_state;
      pending_readings.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin : check_readings
      reading_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.level = rsp_tdata[11:0];
         got.pulse = rsp_tdata[24:12];
         got.worn  = rsp_tuser;
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected result, level", -1, int'(got.level));
         end else begin
            want = pending_readings.pop_front();
            if (got.level !== want.level)
               report_mismatch("level", int'(want.level), int'(got.level));
            if (got.pulse !== want.pulse)
               report_mismatch("pulse", int'($signed(want.pulse)), int'($signed(got.pulse)));
            if (got.worn !== want.worn)
               report_mismatch("worn", int'(want.worn), int'(got.worn));
         end
      end
   end

   // called at a falling edge, returns at a falling edge with valid still up
   task automatic send_sample(input int s);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, s[ppgema_pkg::SAMPLE_W-1:0]};
      do @(posedge clock); while (!req_tready);
      advance_filter_chain(s[ppgema_pkg::SAMPLE_W-1:0]);
      @(negedge clock);
   endtask

   task automatic wait_idle;
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [ppgema_pkg::ADDR_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[16:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         ppgema_pkg::REG_SMOOTH_COEFF:   k_smooth   = value & 'h1FFFF;
         ppgema_pkg::REG_BASELINE_COEFF: k_base     = value & 'h1FFFF;
         ppgema_pkg::REG_PULSE_COEFF:    k_pulse    = value & 'h1FFFF;
         ppgema_pkg::REG_WEAR_LEVEL:     wear_thr   = value & 'hFFF;
         ppgema_pkg::REG_DEBOUNCE:       settle_len = value & 'h3FFF;
         default: ;
      endcase
   endtask

   task automatic set_filter(input int ks, input int kb, input int kp, input int thr,
                             input int deb);
      wait_idle();
      write_csr(ppgema_pkg::REG_SMOOTH_COEFF, ks);
      write_csr(ppgema_pkg::REG_BASELINE_COEFF, kb);
      write_csr(ppgema_pkg::REG_PULSE_COEFF, kp);
      write_csr(ppgema_pkg::REG_WEAR_LEVEL, thr);
      write_csr(ppgema_pkg::REG_DEBOUNCE, deb);
   endtask

   function automatic int pick_coeff();
      case ($urandom_range(5))
         0: return 0;
         1: return COEFF_ONE;
         2: return $urandom_range(COEFF_ONE + 1, COEFF_MAX);
         default: return $urandom_range(1, COEFF_ONE - 1);
      endcase
   endfunction

   function automatic int pick_threshold(input int center);
      case ($urandom_range(3))
         0: return 0;
         1: return SAMPLE_MAX;
         default: return clamp_sample(center + int'($urandom_range(200)) - 100);
      endcase
   endfunction

   function automatic int pick_debounce();
      case ($urandom_range(4))
         0: return 0;
         1: return DEBOUNCE_MAX;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   // first sample seeds the filters, with the reset configuration
   task automatic test_seed_and_defaults;
      send_sample(SAMPLE_MAX);
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(2048);
   endtask

   task automatic test_coeff_extremes;
      set_filter(COEFF_ONE, 0, COEFF_MAX, 0, 25);
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(1);
      set_filter(0, COEFF_ONE, 0, SAMPLE_MAX, 25);
      send_sample(SAMPLE_MAX);
      send_sample(100);
      // coefficients above one act as one
      set_filter(COEFF_ONE + 1, COEFF_MAX, COEFF_ONE, 0, 25);
      send_sample(SAMPLE_MAX);
      send_sample(0);
   endtask

   task automatic test_wear_debounce;
      // zero debounce: flag follows every sample
      set_filter(COEFF_ONE, int'(ppgema_pkg::BASELINE_COEFF_RST), COEFF_ONE, 2000, 0);
      send_sample(3000);
      send_sample(1000);
      send_sample(3000);
      set_filter(COEFF_ONE, int'(ppgema_pkg::BASELINE_COEFF_RST), COEFF_ONE, 2000, 3);
      repeat (4) send_sample(3000);
      repeat (4) send_sample(1000);
      set_filter(COEFF_ONE, int'(ppgema_pkg::BASELINE_COEFF_RST), COEFF_ONE, SAMPLE_MAX,
                 DEBOUNCE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(0);
   endtask

   // writes to unmapped indexes must leave the configuration alone
   task automatic test_unused_index;
      wait_idle();
      for (int idx = REG_FIRST_UNUSED; idx < (1 << ppgema_pkg::ADDR_W); idx++)
         write_csr(idx[ppgema_pkg::ADDR_W-1:0], COEFF_MAX);
      send_sample(1234);
   endtask

   task automatic test_random_traffic;
      int walk_pos, walk_step;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 85; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 85; end
            default: begin gap_pct = 24; stall_pct = 24; end
         endcase
         for (int setting = 0; setting < 4; setting++) begin
            walk_pos = $urandom_range(SAMPLE_MAX);
            case ($urandom_range(2))
               0: walk_step = 4;
               1: walk_step = 64;
               default: walk_step = 400;
            endcase
            set_filter(pick_coeff(), pick_coeff(), pick_coeff(), pick_threshold(walk_pos),
                       pick_debounce());
            // mostly a wandering optical signal, some raw noise
            for (int n = 0; n < 38; n++) begin
               if ($urandom_range(3) == 0) begin
                  send_sample($urandom_range(SAMPLE_MAX));
               end else begin
                  walk_pos = clamp_sample(walk_pos + int'($urandom_range(2 * walk_step))
                                          - walk_step);
                  send_sample(walk_pos);
               end
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_seed_and_defaults();
      test_coeff_extremes();
      test_wear_debounce();
      test_unused_index();
      test_random_traffic();
      wait_idle();
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/ppgema_pkg.sv
src/ppg_ema_chain_with_wear_debounce.sv
sim/tb.sv
